// ----- sv/has_pkg.sv -----
// ----------------------------------------------------------------------------
// Assignment solver package
// Shared sizes, widths and mark codes for the assignment solver.
// ----------------------------------------------------------------------------
package has_pkg;
  localparam int MAX_DIM   = 16;
  localparam int COST_BITS = 16;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int WORK_W    = COST_BITS + 8;
  localparam int TOT_W     = 20;

  typedef logic [1:0] mark_t;
  localparam mark_t MK_NONE  = 2'd0;
  localparam mark_t MK_STAR  = 2'd1;
  localparam mark_t MK_PRIME = 2'd2;
endpackage

// ----- sv/hungarian_assignment_solver.sv -----
// ----------------------------------------------------------------------------
// Hungarian assignment solver
// Loads a cost matrix, solves the assignment with the Munkres steps, and
// streams one result per row.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one cost per transfer in row-major order, with
// in_tlast on the final element; that transfer starts the solve. The cfg_
// channel writes row_count (index 0), col_count (index 1) and maximize
// (index 2) while the block is idle. After the solve the out_ channel gives
// one transfer per row in row order, carrying the assigned column (-1 when
// none), the total of the original costs, and out_tlast on the last row.
// Loading takes one element per cycle while in_tvalid is high. The solve
// runs a small sequencer that visits one matrix cell at a time. Every cell
// visit has two phases: one to read the memory into a register and one to
// act on the registered value. A solve takes many passes over the padded
// matrix. After the totals pass, results leave one per cycle while
// out_tready is high. in_tready is low from the last element until the last
// result has been taken. A stalled receiver simply holds the current result;
// the sequencer waits. Reset returns the registers to their reset values and
// the block to loading at element zero.
module hungarian_assignment_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cost[15:0]
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // row_index[3:0], assigned_col[8:4], total_cost[28:9]
  output logic        out_tlast,  // final_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import has_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_RMIN, S_RSUB, S_STAR, S_COVER, S_FIND, S_PRIME,
    S_AUG, S_AUGP, S_CLRP, S_HMIN, S_HADJ, S_TOT, S_OUT
  } state_t;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  state_t state_r;
  logic [4:0] rows_cfg_r, cols_cfg_r;
  logic       max_r;
  logic [CELL_W:0] load_cnt_r;
  logic       ph_r;

  logic signed [COST_BITS-1:0] orig_mem [CELLS];
  logic signed [WORK_W-1:0]    work_mem [MAX_DIM][MAX_DIM];
  logic signed [COST_BITS-1:0] o_q_r;
  logic signed [WORK_W-1:0]    w_q_r;

  logic [MAX_DIM-1:0] row_cov_r, col_cov_r;
  logic [DIM_W-1:0]   r_r, c_r;
  logic [DIM_W:0]     n_r, m_r, dim_r;
  logic signed [WORK_W-1:0] acc_r;
  logic               have_r;
  logic [MAX_DIM-1:0] row_star_r, col_star_r;
  logic [DIM_W-1:0]   star_col_r [MAX_DIM];   // star column of each row
  logic [DIM_W-1:0]   star_row_r [MAX_DIM];   // star row of each column
  logic [DIM_W-1:0]   prime_col_r [MAX_DIM];  // prime column of each row
  logic [MAX_DIM-1:0] row_prime_r;
  logic signed [TOT_W-1:0] total_r;

  // Clamped dimensions.
  logic [DIM_W:0] n_c, m_c;
  always_comb begin
    n_c = (rows_cfg_r == 5'd0) ? (DIM_W+1)'(1) :
          (rows_cfg_r > 5'(MAX_DIM)) ? (DIM_W+1)'(MAX_DIM) : (DIM_W+1)'(rows_cfg_r);
    m_c = (cols_cfg_r == 5'd0) ? (DIM_W+1)'(1) :
          (cols_cfg_r > 5'(MAX_DIM)) ? (DIM_W+1)'(MAX_DIM) : (DIM_W+1)'(cols_cfg_r);
  end

  // Cell scan helpers.
  logic last_c, last_cell;
  logic [DIM_W-1:0] r_next, c_next;
  assign last_c    = ({1'b0, c_r} == dim_r - 1'b1);
  assign last_cell = last_c && ({1'b0, r_r} == dim_r - 1'b1);
  assign c_next    = last_c ? '0 : c_r + 1'b1;
  assign r_next    = last_c ? r_r + 1'b1 : r_r;

  logic uncov;
  assign uncov = !row_cov_r[r_r] && !col_cov_r[c_r];

  // The totals pass reads the starred column of the row, the copy pass the
  // current column.
  logic [DIM_W-1:0]  ocol;
  logic [CELL_W-1:0] oaddr;
  assign ocol  = (state_r == S_TOT) ? star_col_r[r_r] : c_r;
  assign oaddr = CELL_W'(r_r) * CELL_W'(m_r) + CELL_W'(ocol);

  // States that act on a memory word spend a read phase first.
  logic rd_state;
  always_comb begin
    unique case (state_r)
      S_INIT, S_RMIN, S_RSUB, S_STAR, S_FIND, S_HMIN, S_HADJ, S_TOT: rd_state = 1'b1;
      default: rd_state = 1'b0;
    endcase
  end

  assign cfg_ready = (state_r == S_LOAD);
  assign in_tready = (state_r == S_LOAD);

  // Registered memory read-out at the sequencer's current cell.
  always_ff @(posedge clk) begin
    w_q_r <= work_mem[r_r][c_r];
    o_q_r <= orig_mem[oaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      rows_cfg_r <= 5'd16;
      cols_cfg_r <= 5'd16;
      max_r      <= 1'b0;
      load_cnt_r <= '0;
      out_tvalid <= 1'b0;
      ph_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS: rows_cfg_r <= cfg_data;
          REG_COLS: cols_cfg_r <= cfg_data;
          REG_MAX:  max_r      <= cfg_data[0];
          default:  ;
        endcase
      end
      if (rd_state && !ph_r) begin
        ph_r <= 1'b1;
      end else begin
        ph_r <= 1'b0;
        unique case (state_r)
          S_LOAD: begin
            if (in_tvalid) begin
              if (load_cnt_r < (CELL_W+1)'(CELLS)) begin
                orig_mem[load_cnt_r[CELL_W-1:0]] <= in_tdata;
                load_cnt_r <= load_cnt_r + 1'b1;
              end
              if (in_tlast) begin
                n_r   <= n_c;
                m_r   <= m_c;
                dim_r <= (n_c > m_c) ? n_c : m_c;
                r_r <= '0; c_r <= '0;
                row_cov_r <= '0; col_cov_r <= '0;
                row_star_r <= '0; col_star_r <= '0; row_prime_r <= '0;
                state_r <= S_INIT;
              end
            end
          end
          S_INIT: begin
            // Copy one cell into the working matrix.
            if ({1'b0, r_r} < n_r && {1'b0, c_r} < m_r)
              work_mem[r_r][c_r] <= max_r ? -WORK_W'(o_q_r) : WORK_W'(o_q_r);
            else
              work_mem[r_r][c_r] <= '0;
            r_r <= r_next; c_r <= c_next;
            if (last_cell) begin
              r_r <= '0; c_r <= '0; state_r <= S_RMIN;
            end
          end
          S_RMIN: begin
            if (c_r == '0 || w_q_r < acc_r) acc_r <= w_q_r;
            c_r <= c_next;
            if (last_c) state_r <= S_RSUB;
          end
          S_RSUB: begin
            work_mem[r_r][c_r] <= w_q_r - acc_r;
            c_r <= c_next; r_r <= r_next;
            if (last_c) state_r <= last_cell ? S_STAR : S_RMIN;
            if (last_cell) begin
              r_r <= '0; c_r <= '0;
            end
          end
          S_STAR: begin
            if (w_q_r == '0 && !row_star_r[r_r] && !col_star_r[c_r]) begin
              row_star_r[r_r] <= 1'b1; col_star_r[c_r] <= 1'b1;
              star_col_r[r_r] <= c_r; star_row_r[c_r] <= r_r;
            end
            r_r <= r_next; c_r <= c_next;
            if (last_cell) begin
              r_r <= '0; c_r <= '0; state_r <= S_COVER;
            end
          end
          S_COVER: begin
            // Cover starred columns; done when all dim columns are covered.
            col_cov_r <= col_star_r;
            row_cov_r <= '0;
            r_r <= '0; c_r <= '0;
            if ($countones(col_star_r) == int'(dim_r)) begin
              r_r <= '0; total_r <= '0; state_r <= S_TOT;
            end else begin
              state_r <= S_FIND;
            end
          end
          S_FIND: begin
            if (uncov && w_q_r == '0) begin
              state_r <= S_PRIME;
            end else begin
              r_r <= r_next; c_r <= c_next;
              if (last_cell) begin
                r_r <= '0; c_r <= '0; have_r <= 1'b0; state_r <= S_HMIN;
              end
            end
          end
          S_PRIME: begin
            row_prime_r[r_r] <= 1'b1; prime_col_r[r_r] <= c_r;
            if (!row_star_r[r_r]) begin
              state_r <= S_AUG;
            end else begin
              row_cov_r[r_r] <= 1'b1;
              col_cov_r[star_col_r[r_r]] <= 1'b0;
              r_r <= '0; c_r <= '0;
              state_r <= S_FIND;
            end
          end
          S_AUG: begin
            // Star the prime at (r,c); unstar the star in column c if any.
            row_star_r[r_r] <= 1'b1; star_col_r[r_r] <= c_r;
            if (col_star_r[c_r] && star_row_r[c_r] != r_r) begin
              row_star_r[star_row_r[c_r]] <= 1'b0;
              star_row_r[c_r] <= r_r;
              r_r <= star_row_r[c_r];
              state_r <= S_AUGP;
            end else begin
              col_star_r[c_r] <= 1'b1; star_row_r[c_r] <= r_r;
              r_r <= '0; c_r <= '0; state_r <= S_CLRP;
            end
          end
          S_AUGP: begin
            if (row_prime_r[r_r]) begin
              c_r <= prime_col_r[r_r]; state_r <= S_AUG;
            end else begin
              r_r <= '0; c_r <= '0; state_r <= S_CLRP;
            end
          end
          S_CLRP: begin
            // All primes are erased after the path has been flipped.
            row_prime_r <= '0; state_r <= S_COVER;
          end
          S_HMIN: begin
            if (uncov && (!have_r || w_q_r < acc_r)) begin
              acc_r <= w_q_r; have_r <= 1'b1;
            end
            r_r <= r_next; c_r <= c_next;
            if (last_cell) begin
              r_r <= '0; c_r <= '0;
              state_r <= S_HADJ;
            end
          end
          S_HADJ: begin
            if (!have_r || acc_r <= '0) begin
              r_r <= '0; total_r <= '0; state_r <= S_TOT;
            end else begin
              if (row_cov_r[r_r] && col_cov_r[c_r]) work_mem[r_r][c_r] <= w_q_r + acc_r;
              else if (uncov) work_mem[r_r][c_r] <= w_q_r - acc_r;
              r_r <= r_next; c_r <= c_next;
              if (last_cell) begin
                r_r <= '0; c_r <= '0; state_r <= S_FIND;
              end
            end
          end
          S_TOT: begin
            if ({1'b0, r_r} < n_r && row_star_r[r_r] && {1'b0, star_col_r[r_r]} < m_r)
              total_r <= total_r + TOT_W'(o_q_r);
            if ({1'b0, r_r} == dim_r - 1'b1) begin
              r_r <= '0; out_tvalid <= 1'b1; state_r <= S_OUT;
            end else begin
              r_r <= r_r + 1'b1;
            end
          end
          S_OUT: begin
            if (out_tready) begin
              if ({1'b0, r_r} == n_r - 1'b1) begin
                out_tvalid <= 1'b0; load_cnt_r <= '0; state_r <= S_LOAD;
              end else begin
                r_r <= r_r + 1'b1;
              end
            end
          end
          default: state_r <= S_LOAD;
        endcase
      end
    end
  end

  logic [4:0] acol;
  assign acol = (row_star_r[r_r] && {1'b0, star_col_r[r_r]} < m_r) ?
                5'(star_col_r[r_r]) : 5'h1f;
  assign out_tdata = {3'd0, total_r, acol, 4'(r_r)};
  assign out_tlast = ({1'b0, r_r} == n_r - 1'b1);
endmodule

// ----- sv/has_checker.sv -----
// ----------------------------------------------------------------------------
// Assignment solver checker
// Port-level properties of the solver, bound to the top level.
// ----------------------------------------------------------------------------
module has_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);
  // Input is never taken while a result is on offer.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready during output");
  // Results come in row order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1) else $error("row order");
  // Total is the same across one solve.
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[28:9] == $past(out_tdata[28:9])) else $error("total changed");
  // The last result frees the input side.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready) else $error("no return");
endmodule

bind hungarian_assignment_solver has_checker u_has_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);
